[sv/rlbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbp_pkg: shared types and constants
// Widths, opcodes and status codes of the row length bucket permutation block.
// ----------------------------------------------------------------------------
package rlbp_pkg;
    localparam int MaxRows    = 4096;
    localparam int MaxRowLen  = 255;
    localparam int PtrBits    = 20;
    localparam int RowAw      = 12;
    localparam int CntW       = 13;
    localparam int LenW       = 8;
    localparam int GrpW       = 9;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0, OP_RPERM = 2'd1, OP_RGRP = 2'd2, OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_LONG = 3'd1, ST_DEC = 3'd2, ST_MANY = 3'd3,
        ST_RANGE = 3'd4, ST_NOTBUILT = 3'd5
    } t_status;
endpackage
`default_nettype wire

[sv/row_length_bucket_permutation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// row_length_bucket_permutation: CSR row sort by length
// Loads a row-pointer list, builds a stable counting sort of rows by length
// and answers reads of the permutation and of the length groups.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. Every
// request gives exactly one result, shown for one cycle with o_done high.
// Loads that do not start the build and unused opcodes answer in the cycle
// after acceptance. Reads go to a synchronous memory, wait in S_RDWAIT and
// answer from there; busy stays high meanwhile.
// A load with last set and no error kept starts the build, which runs on
// the memories with busy high: clearing the 256 bucket counters, counting
// the rows (one length read a cycle), a prefix pass over the buckets, and a
// placing pass over the rows (per row: length read, slot read, then the
// write of the slot counter and of the permutation entry).
// The result of that last load carries the group count, so it comes when
// the build is done.
// After reset no build is valid and no load is in progress; reads answer
// "not built". There is no clearing pass for the row, slot or permutation
// memories: they are only read after the build has written them.
// The receiver cannot stall; results are taken in the cycle they appear.
// ----------------------------------------------------------------------------
module row_length_bucket_permutation (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_op,
    input  wire logic [19:0]                 i_row_pointer,
    input  wire logic                        i_last,
    input  wire logic [12:0]                 i_index,
    output logic                             o_done,
    output logic [12:0]                      o_value,
    output logic [7:0]                       o_group_len,
    output logic [8:0]                       o_group_count,
    output logic [12:0]                      o_row_count,
    output logic [2:0]                       o_status
);
    import rlbp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_CLR, S_CNT, S_PFX, S_PFXW, S_PLRD, S_PLSL, S_PLWR
    } t_state;

    // Memories.
    logic [LenW-1:0]   m_len  [MaxRows];
    logic [RowAw-1:0]  m_perm [MaxRows];
    logic [CntW-1:0]   m_cnt  [256];
    logic [CntW-1:0]   m_slot [256];
    logic [CntW-1:0]   m_gst  [257];
    logic [LenW-1:0]   m_glen [256];

    t_state            r_state;
    logic [PtrBits-1:0] r_prev;
    logic [CntW-1:0]   r_rows;
    logic [GrpW-1:0]   r_groups;
    logic              r_built;
    logic [2:0]        r_err;
    logic              r_loading;
    logic [CntW-1:0]   r_i;       // row / bucket counter of the build passes
    logic [CntW-1:0]   r_pos;
    logic              r_rdv;     // count pass: read data valid
    logic [LenW-1:0]   r_rdlen;
    logic [CntW-1:0]   r_rdcnt;
    logic [RowAw-1:0]  r_rdperm;
    logic [CntW-1:0]   r_rdgst;
    logic [LenW-1:0]   r_rdglen;
    logic [LenW-1:0]   r_cntaddr;
    logic [CntW-1:0]   r_slotq;
    logic [1:0]        r_rop;
    logic              r_rbad;
    logic              r_rend;

    // Load arithmetic.
    logic [PtrBits:0] w_diff;
    assign w_diff = {1'b0, i_row_pointer} - {1'b0, r_prev};
    logic [2:0] w_code;
    always_comb begin
        if (i_row_pointer < r_prev) w_code = ST_DEC;
        else if (w_diff > (PtrBits+1)'(MaxRowLen)) w_code = ST_LONG;
        else if (r_rows >= CntW'(MaxRows)) w_code = ST_MANY;
        else w_code = ST_OK;
    end

    assign busy = (r_state != S_IDLE);
    logic w_acc;
    assign w_acc = start && !busy;

    // Forward the counter on back-to-back hits of the same bucket.
    logic w_fwd;
    assign w_fwd = r_rdv && (r_cntaddr == r_rdlen);

    // Memory ports, one clocked block per memory; m_gst and m_glen share one.
    always_ff @(posedge i_clk) begin
        if (w_acc && t_op'(i_op) == OP_LOAD && r_loading && w_code == ST_OK)
            m_len[r_rows[RowAw-1:0]] <= w_diff[LenW-1:0];
        r_rdlen <= m_len[r_i[RowAw-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_PLWR && r_slotq < CntW'(MaxRows))
            m_perm[r_slotq[RowAw-1:0]] <= r_i[RowAw-1:0];
        r_rdperm <= m_perm[i_index[RowAw-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) m_cnt[r_i[LenW-1:0]] <= '0;
        else if (r_state == S_CNT && r_rdv) m_cnt[r_cntaddr] <= r_rdcnt + 1'b1;
        r_rdcnt <= w_fwd ? r_rdcnt + 1'b1
                         : m_cnt[(r_state == S_CNT) ? r_rdlen : r_i[LenW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_PFXW) m_slot[r_i[LenW-1:0]] <= r_pos;
        else if (r_state == S_PLWR) m_slot[r_rdlen] <= r_slotq + 1'b1;
        r_slotq <= m_slot[r_rdlen];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_PFXW && r_rdcnt != '0) begin
            m_gst[r_groups] <= r_pos;
            m_glen[r_groups[LenW-1:0]] <= r_i[LenW-1:0];
        end else if (r_state == S_PFX && r_i == CntW'(256))
            m_gst[r_groups] <= r_pos;
        r_rdgst  <= m_gst[i_index[GrpW-1:0]];
        r_rdglen <= m_glen[i_index[LenW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_prev <= '0; r_rows <= '0; r_groups <= '0;
            r_built <= 1'b0; r_err <= ST_OK; r_loading <= 1'b0; o_done <= 1'b0;
            r_rdv <= 1'b0; r_i <= '0; r_pos <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (w_acc) begin
                    o_value <= '0; o_group_len <= '0;
                    case (t_op'(i_op))
                        OP_LOAD: begin
                            logic [2:0] v_err;
                            logic [CntW-1:0] v_rows;
                            logic v_build;
                            v_err = r_err; v_rows = r_rows;
                            if (!r_loading) begin
                                v_err = ST_OK; v_rows = '0;
                                r_built <= 1'b0;
                            end else if (w_code != ST_OK) begin
                                if (r_err == ST_OK) v_err = w_code;
                            end else v_rows = r_rows + 1'b1;
                            v_build = i_last && (v_err == ST_OK);
                            r_prev <= i_row_pointer;
                            r_err <= v_err; r_rows <= v_rows;
                            r_loading <= !i_last;
                            if (!r_loading || v_build) r_groups <= '0;
                            // A clean list answers when its build is done.
                            o_done <= !v_build; o_status <= v_err;
                            o_row_count <= v_rows;
                            o_group_count <= (r_loading && r_built) ? r_groups : '0;
                            if (v_build) begin
                                r_state <= S_CLR; r_i <= '0;
                            end
                        end
                        OP_RPERM, OP_RGRP: begin
                            r_rop <= i_op;
                            r_rbad <= (t_op'(i_op) == OP_RPERM) ?
                                (i_index >= r_rows || i_index >= CntW'(MaxRows)) :
                                (i_index > {4'b0, r_groups});
                            r_rend <= (i_index == {4'b0, r_groups});
                            r_state <= S_RDWAIT;
                        end
                        default: begin
                            o_done <= 1'b1; o_status <= r_err;
                            o_row_count <= r_rows;
                            o_group_count <= r_built ? r_groups : '0;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    o_done <= 1'b1; r_state <= S_IDLE;
                    o_row_count <= r_rows;
                    o_group_count <= r_built ? r_groups : '0;
                    if (!r_built) o_status <= ST_NOTBUILT;
                    else if (r_rbad) o_status <= ST_RANGE;
                    else begin
                        o_status <= ST_OK;
                        if (t_op'(r_rop) == OP_RPERM) o_value <= {1'b0, r_rdperm};
                        else begin
                            o_value <= r_rdgst;
                            o_group_len <= r_rend ? '0 : r_rdglen;
                        end
                    end
                end
                S_CLR: begin
                    if (r_i == CntW'(255)) begin
                        r_i <= '0; r_rdv <= 1'b0; r_state <= S_CNT;
                    end else r_i <= r_i + 1'b1;
                end
                S_CNT: begin
                    // r_rdlen holds length of row r_i-1 when r_i > 0.
                    r_rdv <= (r_i != '0) && (r_i <= r_rows);
                    r_cntaddr <= r_rdlen;
                    if (r_i > r_rows) begin
                        r_state <= S_PFX; r_i <= '0; r_pos <= '0;
                    end else r_i <= r_i + 1'b1;
                end
                S_PFX: begin
                    if (r_i == CntW'(256)) begin
                        r_state <= S_PLRD; r_i <= '0; r_built <= 1'b0;
                    end else r_state <= S_PFXW;
                end
                S_PFXW: begin
                    if (r_rdcnt != '0) r_groups <= r_groups + 1'b1;
                    r_pos <= r_pos + r_rdcnt;
                    r_i <= r_i + 1'b1; r_state <= S_PFX;
                end
                S_PLRD: begin
                    // The length of row r_i is read at the end of this cycle.
                    if (r_i >= r_rows) begin
                        r_built <= 1'b1; r_state <= S_IDLE;
                        o_done <= 1'b1; o_status <= ST_OK;
                        o_row_count <= r_rows; o_group_count <= r_groups;
                    end else r_state <= S_PLSL;
                end
                S_PLSL: begin
                    // The slot counter of that length is read now.
                    r_state <= S_PLWR;
                end
                S_PLWR: begin
                    r_i <= r_i + 1'b1; r_state <= S_PLRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A read is answered right after its wait cycle.
    ap_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDWAIT) |=> (o_done && r_state == S_IDLE));
    // Every result carries a defined status code.
    ap_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_NOTBUILT));
    // A valid build never coexists with a load in progress.
    ap_built_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> !r_loading);
    // There are at most as many groups as lengths.
    ap_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_groups <= GrpW'(256));
endmodule
`default_nettype wire
